[hw/rtl/oav_pkg.sv]
`default_nettype none

package oav_pkg;

   localparam int PHASE_W     = 32;
   localparam int TIME_W      = 24;
   localparam int AMP_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int WAVE_W      = 16;
   localparam int FACTOR_W    = TIME_W + GAIN_W;
   localparam int DIV_STEPS   = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int STAGE_W     = 3;

   localparam logic [GAIN_W-1:0] UNITY_GAIN   = 16'd32768;
   localparam logic [GAIN_W-1:0] SUSTAIN_GAIN = 16'd19661;
   localparam logic [GAIN_W-1:0] DECAY_DROP   = 16'd13107;

   localparam logic [TIME_W-1:0] ELAPSED_MAX         = '1;
   localparam logic [TIME_W-1:0] ATTACK_END_RESET    = 24'd2400;
   localparam logic [TIME_W-1:0] DECAY_END_RESET     = 24'd4800;
   localparam logic [TIME_W-1:0] SUSTAIN_END_RESET   = 24'd48000;
   localparam logic [TIME_W-1:0] RELEASE_TIME_RESET  = 24'd4800;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_NOTE_OFF = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_TRIANGLE = 2'd1,
      WAVE_SAWTOOTH = 2'd2
   } wave_type;

   typedef enum logic [STAGE_W-1:0] {
      STAGE_ATTACK  = 3'd0,
      STAGE_DECAY   = 3'd1,
      STAGE_SUSTAIN = 3'd2,
      STAGE_RELEASE = 3'd3,
      STAGE_STOP    = 3'd4
   } stage_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAVE_SHAPE   = 3'd0,
      CSR_LIVE_MODE    = 3'd1,
      CSR_ATTACK_END   = 3'd2,
      CSR_DECAY_END    = 3'd3,
      CSR_SUSTAIN_END  = 3'd4,
      CSR_RELEASE_TIME = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic note_on;
      logic note_off;
      logic tick_start;
      logic wave_step;
      logic env_step;
      logic mul_step;
      logic div_step;
      logic scale_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic voice_on;
      logic stop;
   } status_type;

   // Quarter-wave sine by a Taylor series in Q2.30, scaled to 32767.
   function automatic logic signed [WAVE_W-1:0] quarter_sine(input int j, input int bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic [63:0]        v;
      logic signed [63:0] sum;
      x    = (HALF_PI_Q30 * 64'(j)) >> (bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 6; n++) begin
         prod = (term * x2) >> 30;
         unique case (n)
            1: term = prod / 64'd6;
            2: term = prod / 64'd20;
            3: term = prod / 64'd42;
            4: term = prod / 64'd72;
            5: term = prod / 64'd110;
            default: term = prod / 64'd156;
         endcase
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return $signed(WAVE_W'(v));
   endfunction

   function automatic logic signed [WAVE_W-1:0] sine_entry(input int i, input int bits);
      int                       q;
      int                       quad;
      int                       j;
      logic signed [WAVE_W-1:0] v;
      q    = 1 << (bits - 2);
      quad = i >> (bits - 2);
      j    = i & (q - 1);
      if ((quad & 1) != 0) begin
         v = quarter_sine(q - j, bits);
      end else begin
         v = quarter_sine(j, bits);
      end
      return ((quad & 2) != 0) ? -v : v;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/oav_datapath.sv]
`default_nettype none

module oav_datapath #(
   parameter int SINE_TABLE_BITS = 8,
   parameter int SAMPLE_BITS     = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire oav_pkg::cmd_type                      cmd,
   output oav_pkg::status_type                        status,
   input  wire logic [oav_pkg::PHASE_W-1:0]           req_phase_step,
   input  wire logic [oav_pkg::AMP_W-1:0]             req_note_amplitude,
   input  wire logic                                  csr_we,
   input  wire logic [oav_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [oav_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic signed [SAMPLE_BITS-1:0]              rsp_sample,
   output logic [oav_pkg::STAGE_W-1:0]                rsp_stage,
   output logic                                       rsp_active
);

   localparam int ROM_SIZE = 1 << SINE_TABLE_BITS;
   localparam int WP_W     = oav_pkg::WAVE_W + oav_pkg::AMP_W + 1;
   localparam int PROD_W   = WP_W + oav_pkg::GAIN_W + 1;
   localparam int SHIFT    = 47 - SAMPLE_BITS;
   localparam logic signed [PROD_W-1:0] SMAX =
      $signed((PROD_W'(1) << (SAMPLE_BITS - 1)) - PROD_W'(1));
   localparam logic signed [PROD_W-1:0] SMIN = ~SMAX;

   localparam int TW = oav_pkg::TIME_W;
   localparam int GW = oav_pkg::GAIN_W;
   localparam int FW = oav_pkg::FACTOR_W;
   localparam int WW = oav_pkg::WAVE_W;

   logic signed [WW-1:0] sine_rom [ROM_SIZE];

   for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
      assign sine_rom[gi] = oav_pkg::sine_entry(gi, SINE_TABLE_BITS);
   end

   // Configuration.
   logic [1:0]    wave_shape_ff, wave_shape_in;
   logic          live_mode_ff, live_mode_in;
   logic [TW-1:0] attack_end_ff, attack_end_in;
   logic [TW-1:0] decay_end_ff, decay_end_in;
   logic [TW-1:0] sustain_end_ff, sustain_end_in;
   logic [TW-1:0] release_time_ff, release_time_in;

   // Voice state.
   logic [oav_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [oav_pkg::PHASE_W-1:0] step_ff, step_in;
   logic [TW-1:0]               elapsed_ff, elapsed_in;
   logic [oav_pkg::AMP_W-1:0]   peak_ff, peak_in;
   logic                        held_ff, held_in;
   logic [TW-1:0]               rel_start_ff, rel_start_in;
   logic                        voice_on_ff, voice_on_in;

   // Per-tick working registers.
   logic signed [WW-1:0]     rom_q_ff, rom_q_in;
   logic signed [WW-1:0]     wave_ff, wave_in;
   logic signed [WP_W-1:0]   wp_ff, wp_in;
   oav_pkg::stage_type       stage_ff, stage_in;
   logic [TW-1:0]            factor_ff, factor_in;
   logic [GW-1:0]            const_ff, const_in;
   logic [TW-1:0]            divisor_ff, divisor_in;
   logic [FW-1:0]            rem_ff, rem_in;
   logic [FW-1:0]            div_sh_ff, div_sh_in;
   logic [GW-1:0]            quot_ff, quot_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   oav_pkg::stage_type       out_stage_ff, out_stage_in;
   logic                     active_ff, active_in;

   logic signed [WW-1:0]     wave_now;
   logic [16:0]              tri_pos;
   logic [17:0]              tri_abs;
   logic signed [18:0]       tri_val;
   logic [TW-1:0]            rel_d;
   oav_pkg::stage_type       env_stage;
   logic [TW-1:0]            env_factor;
   logic [GW-1:0]            env_const;
   logic [TW-1:0]            env_div;
   logic [GW-1:0]            gain;
   logic signed [PROD_W-1:0] shifted;
   logic                     rem_ge;

   always_comb begin
      tri_pos = phase_ff[oav_pkg::PHASE_W-1 -: 17];
      if (tri_pos[16]) begin
         tri_abs = {2'b00, tri_pos[15:0]};
      end else begin
         tri_abs = 18'd65536 - {1'b0, tri_pos};
      end
      tri_val = $signed({1'b0, tri_abs}) - 19'sd32768;
      case (oav_pkg::wave_type'(wave_shape_ff))
         oav_pkg::WAVE_SINE: wave_now = rom_q_ff;
         oav_pkg::WAVE_TRIANGLE: begin
            if (tri_val > 19'sd32767) begin
               wave_now = 16'sh7fff;
            end else begin
               wave_now = tri_val[WW-1:0];
            end
         end
         oav_pkg::WAVE_SAWTOOTH: begin
            wave_now = {~phase_ff[oav_pkg::PHASE_W-1], phase_ff[oav_pkg::PHASE_W-2 -: WW-1]};
         end
         default: wave_now = '0;
      endcase
   end

   always_comb begin
      rel_d      = (elapsed_ff > rel_start_ff) ? elapsed_ff - rel_start_ff : '0;
      env_stage  = oav_pkg::STAGE_STOP;
      env_factor = '0;
      env_const  = '0;
      env_div    = '0;
      priority if (elapsed_ff < attack_end_ff) begin
         env_stage  = oav_pkg::STAGE_ATTACK;
         env_factor = elapsed_ff;
         env_const  = oav_pkg::UNITY_GAIN;
         env_div    = attack_end_ff;
      end else if (elapsed_ff < decay_end_ff) begin
         env_stage  = oav_pkg::STAGE_DECAY;
         env_factor = elapsed_ff - attack_end_ff;
         env_const  = oav_pkg::DECAY_DROP;
         env_div    = decay_end_ff - attack_end_ff;
      end else if (live_mode_ff) begin
         priority if (held_ff) begin
            env_stage = oav_pkg::STAGE_SUSTAIN;
         end else if (rel_d < release_time_ff) begin
            env_stage  = oav_pkg::STAGE_RELEASE;
            env_factor = release_time_ff - rel_d;
            env_const  = oav_pkg::SUSTAIN_GAIN;
            env_div    = release_time_ff;
         end else begin
            env_stage = oav_pkg::STAGE_STOP;
         end
      end else begin
         priority if (elapsed_ff < sustain_end_ff) begin
            env_stage = oav_pkg::STAGE_SUSTAIN;
         end else if (elapsed_ff < release_time_ff) begin
            env_stage  = oav_pkg::STAGE_RELEASE;
            env_factor = release_time_ff - elapsed_ff;
            env_const  = oav_pkg::SUSTAIN_GAIN;
            env_div    = release_time_ff - sustain_end_ff;
         end else begin
            env_stage = oav_pkg::STAGE_STOP;
         end
      end
   end

   always_comb begin
      unique case (stage_ff)
         oav_pkg::STAGE_DECAY:   gain = oav_pkg::UNITY_GAIN - quot_ff;
         oav_pkg::STAGE_SUSTAIN: gain = oav_pkg::SUSTAIN_GAIN;
         default:                gain = quot_ff;
      endcase
      shifted = prod_ff >>> SHIFT;
      rem_ge  = rem_ff >= div_sh_ff;
   end

   always_comb begin
      wave_shape_in   = wave_shape_ff;
      live_mode_in    = live_mode_ff;
      attack_end_in   = attack_end_ff;
      decay_end_in    = decay_end_ff;
      sustain_end_in  = sustain_end_ff;
      release_time_in = release_time_ff;
      if (csr_we) begin
         case (csr_index)
            oav_pkg::CSR_WAVE_SHAPE:   wave_shape_in   = csr_data[1:0];
            oav_pkg::CSR_LIVE_MODE:    live_mode_in    = csr_data[0];
            oav_pkg::CSR_ATTACK_END:   attack_end_in   = csr_data[TW-1:0];
            oav_pkg::CSR_DECAY_END:    decay_end_in    = csr_data[TW-1:0];
            oav_pkg::CSR_SUSTAIN_END:  sustain_end_in  = csr_data[TW-1:0];
            oav_pkg::CSR_RELEASE_TIME: release_time_in = csr_data[TW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      elapsed_in   = elapsed_ff;
      peak_in      = peak_ff;
      held_in      = held_ff;
      rel_start_in = rel_start_ff;
      voice_on_in  = voice_on_ff;
      if (cmd.note_on) begin
         step_in     = req_phase_step;
         peak_in     = req_note_amplitude;
         phase_in    = '0;
         elapsed_in  = '0;
         held_in     = 1'b1;
         voice_on_in = 1'b1;
      end
      if (cmd.note_off) begin
         held_in = 1'b0;
         if (live_mode_ff) begin
            rel_start_in = (elapsed_ff > decay_end_ff) ? elapsed_ff : decay_end_ff;
         end
      end
      if (cmd.wave_step) begin
         phase_in = phase_ff + step_ff;
         if (elapsed_ff != oav_pkg::ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + TW'(1);
         end
      end
      if (cmd.out_load && (stage_ff == oav_pkg::STAGE_STOP)) begin
         voice_on_in = 1'b0;
      end
   end

   always_comb begin
      rom_q_in     = rom_q_ff;
      wave_in      = wave_ff;
      wp_in        = wp_ff;
      stage_in     = stage_ff;
      factor_in    = factor_ff;
      const_in     = const_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      div_sh_in    = div_sh_ff;
      quot_in      = quot_ff;
      prod_in      = prod_ff;
      sample_in    = sample_ff;
      out_stage_in = out_stage_ff;
      active_in    = active_ff;
      if (cmd.tick_start) begin
         rom_q_in = sine_rom[phase_ff[oav_pkg::PHASE_W-1 -: SINE_TABLE_BITS]];
         if (!voice_on_ff) begin
            stage_in = oav_pkg::STAGE_STOP;
         end
      end
      if (cmd.wave_step) begin
         wave_in = wave_now;
      end
      if (cmd.env_step) begin
         stage_in   = env_stage;
         factor_in  = env_factor;
         const_in   = env_const;
         divisor_in = env_div;
         wp_in      = WP_W'(wave_ff) * WP_W'($signed({1'b0, peak_ff}));
      end
      if (cmd.mul_step) begin
         rem_in    = FW'(factor_ff) * FW'(const_ff);
         div_sh_in = {1'b0, divisor_ff, (GW - 1)'(0)};
         quot_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in    = rem_ge ? rem_ff - div_sh_ff : rem_ff;
         div_sh_in = div_sh_ff >> 1;
         quot_in   = {quot_ff[GW-2:0], rem_ge};
      end
      if (cmd.scale_step) begin
         prod_in = PROD_W'(wp_ff) * PROD_W'($signed({1'b0, gain}));
      end
      if (cmd.out_load) begin
         out_stage_in = stage_ff;
         if (stage_ff == oav_pkg::STAGE_STOP) begin
            sample_in = '0;
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            priority if (shifted > SMAX) begin
               sample_in = SMAX[SAMPLE_BITS-1:0];
            end else if (shifted < SMIN) begin
               sample_in = SMIN[SAMPLE_BITS-1:0];
            end else begin
               sample_in = shifted[SAMPLE_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_shape_ff   <= 2'd0;
         live_mode_ff    <= 1'b1;
         attack_end_ff   <= oav_pkg::ATTACK_END_RESET;
         decay_end_ff    <= oav_pkg::DECAY_END_RESET;
         sustain_end_ff  <= oav_pkg::SUSTAIN_END_RESET;
         release_time_ff <= oav_pkg::RELEASE_TIME_RESET;
         phase_ff        <= '0;
         step_ff         <= '0;
         elapsed_ff      <= '0;
         peak_ff         <= '0;
         held_ff         <= 1'b0;
         rel_start_ff    <= '0;
         voice_on_ff     <= 1'b0;
      end else begin
         wave_shape_ff   <= wave_shape_in;
         live_mode_ff    <= live_mode_in;
         attack_end_ff   <= attack_end_in;
         decay_end_ff    <= decay_end_in;
         sustain_end_ff  <= sustain_end_in;
         release_time_ff <= release_time_in;
         phase_ff        <= phase_in;
         step_ff         <= step_in;
         elapsed_ff      <= elapsed_in;
         peak_ff         <= peak_in;
         held_ff         <= held_in;
         rel_start_ff    <= rel_start_in;
         voice_on_ff     <= voice_on_in;
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff     <= rom_q_in;
      wave_ff      <= wave_in;
      wp_ff        <= wp_in;
      stage_ff     <= stage_in;
      factor_ff    <= factor_in;
      const_ff     <= const_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      div_sh_ff    <= div_sh_in;
      quot_ff      <= quot_in;
      prod_ff      <= prod_in;
      sample_ff    <= sample_in;
      out_stage_ff <= out_stage_in;
      active_ff    <= active_in;
   end

   assign status.voice_on = voice_on_ff;
   assign status.stop     = (stage_ff == oav_pkg::STAGE_STOP);

   assign rsp_sample = sample_ff;
   assign rsp_stage  = out_stage_ff;
   assign rsp_active = active_ff;

endmodule

`default_nettype wire

[hw/rtl/oav_controller.sv]
`default_nettype none

module oav_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [1:0]  req_opcode,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire oav_pkg::status_type status,
   output oav_pkg::cmd_type cmd
);

   localparam int CNT_W = $clog2(oav_pkg::DIV_STEPS);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_WAVE  = 7'b0000010,
      ST_ENV   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   oav_pkg::opcode_type op;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign op     = oav_pkg::opcode_type'(req_opcode);

   always_comb begin
      cmd            = '0;
      cmd.note_on    = accept && (op == oav_pkg::OP_NOTE_ON);
      cmd.note_off   = accept && (op == oav_pkg::OP_NOTE_OFF);
      cmd.tick_start = accept && (op == oav_pkg::OP_TICK);
      cmd.wave_step  = (state_ff == ST_WAVE);
      cmd.env_step   = (state_ff == ST_ENV);
      cmd.mul_step   = (state_ff == ST_MUL);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.scale_step = (state_ff == ST_SCALE);
      cmd.out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.tick_start) begin
               state_in = status.voice_on ? ST_WAVE : ST_DONE;
            end
         end
         ST_WAVE: state_in = ST_ENV;
         ST_ENV:  state_in = ST_MUL;
         ST_MUL: begin
            if (status.stop) begin
               state_in = ST_DONE;
            end else begin
               state_in   = ST_DIV;
               div_cnt_in = CNT_W'(oav_pkg::DIV_STEPS - 1);
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               div_cnt_in = div_cnt_ff - CNT_W'(1);
            end
         end
         ST_SCALE: state_in = ST_DONE;
         ST_DONE: begin
            if (cmd.out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/oscillator_adsr_voice.sv]
`default_nettype none

// One synthesizer voice: a phase-accumulator oscillator (sine from a table, triangle or
// sawtooth) scaled by the note amplitude and an ADSR envelope. Note-on and note-off words
// are absorbed in the cycle they are accepted and give no result. A tick word gives one
// result word; an active tick runs the wave, envelope, multiply, divide and scale steps
// before a new word is taken, most of its time in the 16-step restoring divider that
// forms the envelope gain; a tick that reaches the stop stage skips the divide and scale
// steps and a tick on a silent voice goes straight to its result. A finished result waits
// in the output register, and a new word is accepted while it waits; a result that finds
// the output register still stalled holds the block until taken. Configuration
// writes are always ready and should be issued only while the voice has no tick in flight.
module oscillator_adsr_voice #(
   parameter int SINE_TABLE_BITS = 8,
   parameter int SAMPLE_BITS     = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [oav_pkg::PHASE_W-1:0]        req_phase_step,
   input  wire logic [oav_pkg::AMP_W-1:0]          req_note_amplitude,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample,
   output logic [oav_pkg::STAGE_W-1:0]             rsp_stage,
   output logic                                    rsp_active,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [oav_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [oav_pkg::CSR_DATA_W-1:0]     csr_data
);

   oav_pkg::cmd_type    cmd;
   oav_pkg::status_type status;
   logic                csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   oav_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   oav_datapath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_phase_step     (req_phase_step),
      .req_note_amplitude (req_note_amplitude),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_sample         (rsp_sample),
      .rsp_stage          (rsp_stage),
      .rsp_active         (rsp_active)
   );

   a_silent_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> (rsp_sample == '0) && (rsp_stage == oav_pkg::STAGE_STOP))
      else $error("Inactive result word carries a nonzero sample or a live stage.");

   a_live_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active |-> (rsp_stage != oav_pkg::STAGE_STOP))
      else $error("Active result word reports the stop stage.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("Output register loaded while a stalled word is pending.");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == oav_pkg::OP_TICK) |=> req_stall)
      else $error("Block took a new word right after accepting a tick.");

endmodule

`default_nettype wire

[tb/sv/oscillator_adsr_voice_tb.sv]
`timescale 1ns / 100ps

import oav_pkg::*;

localparam int              TABLE_BITS   = 8;
localparam longint          FULL_GAIN    = 32768;
localparam longint          HOLD_GAIN    = 19661;
localparam longint          FALL_GAIN    = 13107;
localparam longint unsigned HALF_PI_FRAC = 64'd1686629713;
localparam logic [23:0]     TIME_MAX     = 24'hFFFFFF;

typedef struct packed {
   logic signed [15:0] sample;
   stage_type          stage;
   logic               active;
} voice_out_t;

class voice_model;
   int          errors;
   voice_out_t  upcoming_outputs[$];
   int          sine_rom [1 << TABLE_BITS];
   logic [1:0]  shape;
   logic        live;
   logic [23:0] attack_end;
   logic [23:0] decay_end;
   logic [23:0] sustain_end;
   logic [23:0] release_len;
   logic [31:0] phase;
   logic [31:0] step_size;
   logic [23:0] elapsed;
   logic [23:0] release_start;
   logic [15:0] peak;
   logic        held;
   logic        sounding;

   function new();
      int quarter;
      int quad;
      int v;
      quarter = (1 << TABLE_BITS) / 4;
      for (int i = 0; i < (1 << TABLE_BITS); i++) begin
         quad = i / quarter;
         v = quarter_wave((quad % 2 == 1) ? quarter - i % quarter : i % quarter);
         sine_rom[i] = (quad >= 2) ? -v : v;
      end
      errors        = 0;
      shape         = WAVE_SINE;
      live          = 1'b1;
      attack_end    = 24'd2400;
      decay_end     = 24'd4800;
      sustain_end   = 24'd48000;
      release_len   = 24'd4800;
      phase         = '0;
      step_size     = '0;
      elapsed       = '0;
      release_start = '0;
      peak          = '0;
      held          = 1'b0;
      sounding      = 1'b0;
   endfunction

   // Quarter-wave sine from a Taylor series in Q2.30, rounded to 32767 full scale.
   function int quarter_wave(int j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint unsigned divisor;
      longint unsigned jj;
      longint          sum;
      jj   = j;
      x    = (HALF_PI_FRAC * jj) >> (TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         divisor = 2 * n * (2 * n + 1);
         term = ((term * x2) >> 30) / divisor;
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return int'(v);
   endfunction

   function int wave_now();
      int v;
      case (shape)
         WAVE_SINE: begin
            return sine_rom[phase[31 -: TABLE_BITS]];
         end
         WAVE_TRIANGLE: begin
            v = int'({15'd0, phase[31:15]}) - 65536;
            if (v < 0) begin
               v = -v;
            end
            v = v - 32768;
            return (v > 32767) ? 32767 : v;
         end
         WAVE_SAWTOOTH: begin
            return int'({16'd0, phase[31:16]}) - 32768;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function void write_reg(csr_index_type idx, logic [23:0] data);
      case (idx)
         CSR_WAVE_SHAPE:   shape = data[1:0];
         CSR_LIVE_MODE:    live = data[0];
         CSR_ATTACK_END:   attack_end = data;
         CSR_DECAY_END:    decay_end = data;
         CSR_SUSTAIN_END:  sustain_end = data;
         CSR_RELEASE_TIME: release_len = data;
         default: ;
      endcase
   endfunction

   function void apply_word(logic [1:0] op, logic [31:0] step_in, logic [15:0] amp_in);
      int         w;
      longint     t;
      longint     g;
      longint     p;
      longint     s;
      longint     d;
      longint     ae;
      longint     de;
      longint     se;
      longint     rt;
      longint     pk;
      voice_out_t res;
      if (op == OP_NOTE_ON) begin
         step_size = step_in;
         peak      = amp_in;
         phase     = '0;
         elapsed   = '0;
         held      = 1'b1;
         sounding  = 1'b1;
         return;
      end
      if (op == OP_NOTE_OFF) begin
         held = 1'b0;
         if (live) begin
            release_start = (elapsed > decay_end) ? elapsed : decay_end;
         end
         return;
      end
      if (op != OP_TICK) begin
         return;
      end
      res.sample = '0;
      res.stage  = STAGE_STOP;
      res.active = 1'b0;
      if (!sounding) begin
         upcoming_outputs.push_back(res);
         return;
      end
      w = wave_now();
      phase = phase + step_size;
      if (elapsed != TIME_MAX) begin
         elapsed = elapsed + 24'd1;
      end
      t  = elapsed;
      ae = attack_end;
      de = decay_end;
      se = sustain_end;
      rt = release_len;
      g  = 0;
      if (t < ae) begin
         g = t * FULL_GAIN / ae;
         res.stage = STAGE_ATTACK;
      end else if (t < de) begin
         g = FULL_GAIN - (t - ae) * FALL_GAIN / (de - ae);
         res.stage = STAGE_DECAY;
      end else if (live) begin
         d = (t > release_start) ? t - release_start : 0;
         if (held) begin
            g = HOLD_GAIN;
            res.stage = STAGE_SUSTAIN;
         end else if (d < rt) begin
            g = (rt - d) * HOLD_GAIN / rt;
            res.stage = STAGE_RELEASE;
         end
      end else begin
         if (t < se) begin
            g = HOLD_GAIN;
            res.stage = STAGE_SUSTAIN;
         end else if (t < rt) begin
            g = (rt - t) * HOLD_GAIN / (rt - se);
            res.stage = STAGE_RELEASE;
         end
      end
      if (res.stage == STAGE_STOP) begin
         sounding = 1'b0;
         upcoming_outputs.push_back(res);
         return;
      end
      pk = peak;
      p  = longint'(w) * pk * g;
      s  = p >>> 31;
      if (s > 32767) begin
         s = 32767;
      end
      if (s < -32768) begin
         s = -32768;
      end
      res.sample = 16'(s);
      res.active = 1'b1;
      upcoming_outputs.push_back(res);
   endfunction

   function int pending();
      return upcoming_outputs.size();
   endfunction

   task report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   task compare_output(logic signed [15:0] got_sample, logic [2:0] got_stage, logic got_active);
      voice_out_t want;
      if (upcoming_outputs.size() == 0) begin
         report_mismatch("word with nothing pending, sample", got_sample, 0);
         return;
      end
      want = upcoming_outputs.pop_front();
      if (got_sample !== want.sample) begin
         report_mismatch("sample", got_sample, want.sample);
      end
      if (got_stage !== want.stage) begin
         report_mismatch("stage", got_stage, want.stage);
      end
      if (got_active !== want.active) begin
         report_mismatch("active", got_active, want.active);
      end
   endtask
endclass

module oscillator_adsr_voice_tb;

   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         DRAIN_CYCLES    = 30;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam logic [1:0] OP_IGNORED      = 2'd3;
   localparam logic [1:0] WAVE_NONE       = 2'd3;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_opcode         = '0;
   logic [PHASE_W-1:0]       req_phase_step     = '0;
   logic [AMP_W-1:0]         req_note_amplitude = '0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic signed [15:0]       rsp_sample;
   logic [STAGE_W-1:0]       rsp_stage;
   logic                     rsp_active;
   logic                     csr_valid          = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index          = '0;
   logic [CSR_DATA_W-1:0]    csr_data           = '0;

   int         cycle_count  = 0;
   int         send_gap_pct = 0;
   int         stall_pct    = 0;
   int         hold_left    = 0;
   voice_model voice        = new();

   oscillator_adsr_voice u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_phase_step     (req_phase_step),
      .req_note_amplitude (req_note_amplitude),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_stage          (rsp_stage),
      .rsp_active         (rsp_active),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         voice.compare_output(rsp_sample, rsp_stage, rsp_active);
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [31:0] step_in,
                            input logic [15:0] amp_in);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_phase_step     <= step_in;
      req_note_amplitude <= amp_in;
      do @(posedge clock); while (req_stall !== 1'b0);
      voice.apply_word(op, step_in, amp_in);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (voice.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [1:0] shape_val, input logic live_val,
                             input logic [23:0] ae, input logic [23:0] de,
                             input logic [23:0] se, input logic [23:0] rt);
      logic [23:0]   value [6];
      csr_index_type regs [6];
      settle();
      value = '{24'(shape_val), 24'(live_val), ae, de, se, rt};
      regs  = '{CSR_WAVE_SHAPE, CSR_LIVE_MODE, CSR_ATTACK_END,
                CSR_DECAY_END, CSR_SUSTAIN_END, CSR_RELEASE_TIME};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= value[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         voice.write_reg(regs[i], value[i]);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          sent;
      int          ticks;
      int          off_at;
      logic [1:0]  op;
      logic [31:0] step_val;
      logic [15:0] amp_val;
      logic [1:0]  shape_val;
      logic        live_val;
      logic [23:0] ae;
      logic [23:0] de;
      logic [23:0] se;
      logic [23:0] rt;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A silent voice, an unused opcode and a note-off with no note playing.
      send_word(OP_TICK, '0, '0);
      send_word(OP_IGNORED, '1, '1);
      send_word(OP_NOTE_OFF, '0, '0);

      write_regs(WAVE_SINE, 1'b1, 24'd2, 24'd4, 24'd0, 24'd3);
      send_word(OP_NOTE_ON, '1, '1);
      repeat (5) send_word(OP_TICK, '0, '0);
      send_word(OP_NOTE_OFF, '1, '1);
      repeat (4) send_word(OP_TICK, '1, '1);

      // Fixed sustain with empty attack and decay segments.
      write_regs(WAVE_TRIANGLE, 1'b0, 24'd0, 24'd0, 24'd2, 24'd4);
      send_word(OP_NOTE_ON, 32'h8000_0000, 16'h8000);
      repeat (4) send_word(OP_TICK, '0, '0);

      // Full negative sawtooth at unity gain drives the sample to its minimum.
      write_regs(WAVE_SAWTOOTH, 1'b0, 24'd1, 24'd3, 24'd3, 24'd5);
      send_word(OP_NOTE_ON, 32'h1234_5678, 16'hFFFF);
      repeat (2) send_word(OP_TICK, '0, '0);

      write_regs(WAVE_NONE, 1'b1, '1, '1, '1, '1);
      send_word(OP_NOTE_ON, '0, '0);
      send_word(OP_TICK, '0, '0);

      // Moving the decay end below the captured release start mid-note.
      write_regs(WAVE_SINE, 1'b1, 24'd1, 24'd10, 24'd0, '1);
      send_word(OP_NOTE_ON, 32'h0100_0000, 16'hFFFF);
      send_word(OP_TICK, '0, '0);
      send_word(OP_NOTE_OFF, '0, '0);
      write_regs(WAVE_SINE, 1'b1, 24'd0, 24'd0, 24'd0, 24'd4);
      repeat (2) send_word(OP_TICK, '0, '0);

      for (int n = 0; n < 8; n++) begin
         shape_val = 2'($urandom_range(3));
         live_val  = 1'($urandom_range(1));
         if (n == 5 || $urandom_range(7) == 0) begin
            ae = 24'($urandom);
            de = 24'($urandom);
            se = 24'($urandom);
            rt = 24'($urandom);
         end else begin
            ae = 24'($urandom_range(10));
            de = ($urandom_range(4) == 0) ? 24'($urandom_range(ae)) : ae + 24'($urandom_range(10));
            se = de + 24'($urandom_range(12));
            rt = live_val ? 24'($urandom_range(10)) : se + 24'($urandom_range(10));
         end
         write_regs(shape_val, live_val, ae, de, se, rt);
         case (n % 4)
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
            1: begin
               send_gap_pct = 46;
               stall_pct    = 0;
            end
            2: begin
               send_gap_pct = 0;
               stall_pct    = 46;
            end
            default: begin
               send_gap_pct = 15;
               stall_pct    = 15;
            end
         endcase
         sent = 0;
         if (n == 0) begin
            send_word(OP_NOTE_ON, $urandom, 16'hFFFF);
            sent = 1;
            hold_left = HOLD_OFF_CYCLES;
         end
         while (sent < 80) begin
            if ($urandom_range(9) == 0) begin
               op = 2'($urandom_range(3));
               send_word(op, $urandom, 16'($urandom));
               if (op != OP_IGNORED) begin
                  sent++;
               end
            end else begin
               step_val = ($urandom_range(2) == 0) ? 32'($urandom_range(32'h00FF_FFFF)) : $urandom;
               amp_val  = ($urandom_range(5) == 0) ? {16{1'($urandom_range(1))}} : 16'($urandom);
               send_word(OP_NOTE_ON, step_val, amp_val);
               sent++;
               ticks  = $urandom_range(24, 1);
               off_at = ($urandom_range(4) == 0) ? ticks + 1 : $urandom_range(ticks);
               for (int k = 0; k <= ticks; k++) begin
                  if (k == off_at) begin
                     send_word(OP_NOTE_OFF, $urandom, 16'($urandom));
                     sent++;
                  end
                  if (k < ticks) begin
                     send_word(OP_TICK, $urandom, 16'($urandom));
                     sent++;
                  end
               end
            end
         end
      end

      settle();
      if (voice.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/oav_pkg.sv
hw/rtl/oav_datapath.sv
hw/rtl/oav_controller.sv
hw/rtl/oscillator_adsr_voice.sv
tb/sv/oscillator_adsr_voice_tb.sv
